// ----- rtl/rd_pkg.sv -----
// Shared types and constants of the restoring divider.
package rd_pkg;

    localparam int FIELD_W = 32;

    typedef logic [FIELD_W-1:0] field_t;

endpackage

// ----- rtl/rd_op_if.sv -----
// Operand channel: valid/ready handshake carrying dividend and divisor.
interface rd_op_if;

    import rd_pkg::*;

    logic   valid;
    logic   ready;
    field_t dividend;
    field_t divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);

endinterface

// ----- rtl/rd_res_if.sv -----
// Result channel: valid/ready handshake carrying quotient and remainder.
interface rd_res_if;

    import rd_pkg::*;

    logic   valid;
    logic   ready;
    field_t quotient;
    field_t remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink   (input valid, input quotient, input remainder, output ready);

endinterface

// ----- rtl/rd_stage.sv -----
// One restoring division step followed by its pipeline register.
module rd_stage #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_rem,
    input  logic [WIDTH-1:0] in_quo,
    input  logic [WIDTH-1:0] in_den,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_rem,
    output logic [WIDTH-1:0] out_quo,
    output logic [WIDTH-1:0] out_den
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] den_reg;
    logic [WIDTH-1:0] shifted;
    logic [WIDTH+1:0] trial;
    logic             fits;
    logic             load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // shift in the next dividend bit and try the subtraction one bit wider
    assign shifted = {in_rem[WIDTH-2:0], in_quo[WIDTH-1]};
    assign trial   = {1'b0, in_rem[WIDTH-1], shifted} - {2'b00, in_den};
    assign fits    = !trial[WIDTH+1];

    always_comb
    begin
        rem_next   = fits ? trial[WIDTH-1:0] : shifted;
        quo_next   = {in_quo[WIDTH-2:0], fits};
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= in_den;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;

endmodule

// ----- rtl/restoring_unsigned_divider.sv -----
// Top level of the pipelined restoring unsigned divider.
//
// Usage:
//   operands (sink): dividend and divisor; the low WIDTH bits of each are used.
//   results (source): quotient and remainder, zero-extended or cut to 32 bits.
//   An item moves on a rising edge with valid and ready both high.
//   One restoring stage per quotient bit, each with its own register, so an
//   item passes through the stage registers in order, from the first stage
//   to the last, before it reaches the results channel.
//   Throughput is one item per cycle while results.ready is high.
//   A zero divisor gives an all-ones quotient and the dividend as remainder.
//   Reset clears every stage valid bit; the pipeline comes up empty.
//   When the receiver stalls, each full stage holds its item and a stage
//   takes a new one only when it is empty or its contents move on, so
//   bubbles close up and no item is lost or repeated; operands.ready falls
//   once every stage is full.
module restoring_unsigned_divider #(
    parameter int WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    rd_op_if.sink    operands,
    rd_res_if.source results
);

    import rd_pkg::*;

    logic             vld [WIDTH+1];
    logic             rdy [WIDTH+1];
    logic [WIDTH-1:0] rem [WIDTH+1];
    logic [WIDTH-1:0] quo [WIDTH+1];
    logic [WIDTH-1:0] den [WIDTH+1];

    assign vld[0]         = operands.valid;
    assign operands.ready = rdy[0];
    assign rem[0]         = '0;
    assign quo[0]         = WIDTH'(operands.dividend);
    assign den[0]         = WIDTH'(operands.divisor);

    for (genvar s = 0; s < WIDTH; s++)
    begin : g_stage
        rd_stage #(
            .WIDTH (WIDTH)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[s]),
            .in_ready  (rdy[s]),
            .in_rem    (rem[s]),
            .in_quo    (quo[s]),
            .in_den    (den[s]),
            .out_valid (vld[s+1]),
            .out_ready (rdy[s+1]),
            .out_rem   (rem[s+1]),
            .out_quo   (quo[s+1]),
            .out_den   (den[s+1])
        );
    end

    assign rdy[WIDTH]        = results.ready;
    assign results.valid     = vld[WIDTH];
    assign results.quotient  = FIELD_W'(quo[WIDTH]);
    assign results.remainder = FIELD_W'(rem[WIDTH]);

endmodule

// ----- rtl/rd_checker.sv -----
// Port-level checks of the restoring divider and their binding.
module rd_checker #(
    parameter int WIDTH = 32
) (
    input logic           clk,
    input logic           rst_n,
    input logic           op_ready,
    input logic           res_valid,
    input logic           res_ready,
    input rd_pkg::field_t quotient,
    input rd_pkg::field_t remainder
);

    import rd_pkg::*;

    localparam field_t WMASK = (WIDTH >= FIELD_W) ? '1 : FIELD_W'((64'd1 << WIDTH) - 64'd1);

    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(quotient) && $stable(remainder))
        else $error("stalled result changed");

    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> op_ready)
        else $error("operands stalled while results drain");

    a_result_width: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((quotient & ~WMASK) == '0) && ((remainder & ~WMASK) == '0))
        else $error("result bits above WIDTH set");

endmodule

bind restoring_unsigned_divider rd_checker #(
    .WIDTH (WIDTH)
) u_rd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_ready  (operands.ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .quotient  (results.quotient),
    .remainder (results.remainder)
);

// ----- sim/restoring_unsigned_divider_test.sv -----
// Self-checking testbench of the pipelined restoring unsigned divider.
`timescale 1ns / 1ps

module restoring_unsigned_divider_test;

    import rd_pkg::*;

    localparam int LATENCY    = FIELD_W;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM   = 1500;

    typedef struct {
        field_t dividend;
        field_t divisor;
        field_t quotient;
        field_t remainder;
    } division_t;

    class division_scoreboard;

        division_t owed_divisions[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return owed_divisions.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Shift-and-subtract with a partial remainder one bit wider than a field.
        function void note_operands(field_t dividend, field_t divisor);
            logic [FIELD_W:0] part;
            field_t           quo;
            division_t        d;
            int               step;
            part = '0;
            quo  = dividend;
            for (step = 0; step < FIELD_W; step++)
            begin
                part = {part[FIELD_W-1:0], quo[FIELD_W-1]};
                quo  = quo << 1;
                if (part >= {1'b0, divisor})
                begin
                    part   = part - {1'b0, divisor};
                    quo[0] = 1'b1;
                end
            end
            d.dividend  = dividend;
            d.divisor   = divisor;
            d.quotient  = quo;
            d.remainder = part[FIELD_W-1:0];
            owed_divisions.push_back(d);
        endfunction

        task check_result(field_t quotient, field_t remainder);
            division_t d;
            if (owed_divisions.size() == 0)
            begin
                report($sformatf("unexpected item q=%h r=%h", quotient, remainder));
                return;
            end
            d = owed_divisions.pop_front();
            if (quotient !== d.quotient)
                report($sformatf("%h / %h: quotient %h, expected %h",
                                 d.dividend, d.divisor, quotient, d.quotient));
            if (remainder !== d.remainder)
                report($sformatf("%h / %h: remainder %h, expected %h",
                                 d.dividend, d.divisor, remainder, d.remainder));
        endtask

    endclass

    logic clk;
    logic rst_n;
    bit   steady;

    rd_op_if  operands();
    rd_res_if results();

    division_scoreboard divisions = new();

    restoring_unsigned_divider #(
        .WIDTH(FIELD_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .operands(operands),
        .results(results)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic field_t pick_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return field_t'($urandom) >> $urandom_range(0, FIELD_W - 1);
            2: return '1 - field_t'($urandom_range(0, 15));
            3: return field_t'(1) << $urandom_range(0, FIELD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_operands(field_t dividend, field_t divisor);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            operands.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operands.valid    <= 1'b1;
        operands.dividend <= dividend;
        operands.divisor  <= divisor;
        do
            @(posedge clk);
        while (!operands.ready);
    endtask

    task automatic drain();
        operands.valid <= 1'b0;
        @(posedge clk);
        while (divisions.pending() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (operands.valid && operands.ready)
            divisions.note_operands(operands.dividend, operands.divisor);
        if (results.valid && results.ready)
            divisions.check_result(results.quotient, results.remainder);
    end

    initial
    begin
        int stall;
        results.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            results.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                results.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((operands.valid && operands.ready) || (results.valid && results.ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        field_t dividend;
        field_t divisor;
        int     i;
        steady            = 1'b0;
        rst_n             <= 1'b0;
        operands.valid    <= 1'b0;
        operands.dividend <= '0;
        operands.divisor  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_operands('0, '0);
        send_operands('1, '0);
        send_operands(32'd123, '0);
        send_operands('0, '1);
        send_operands('1, '1);
        send_operands('1, 32'd1);
        send_operands(32'd1, '1);
        send_operands(32'd1, 32'd1);
        send_operands('1, 32'd2);
        send_operands(32'h8000_0000, 32'd1);
        send_operands(32'h8000_0000, 32'h8000_0000);
        send_operands(32'h8000_0001, 32'h8000_0000);
        send_operands(32'h7FFF_FFFF, 32'h8000_0000);
        send_operands('1, 32'h8000_0000);
        send_operands('1, 32'h7FFF_FFFF);
        send_operands(32'd100, 32'd7);
        send_operands(32'd7, 32'd100);
        send_operands(32'hAAAA_AAAA, 32'h5555_5555);
        send_operands(32'h5555_5555, 32'hAAAA_AAAA);
        send_operands(32'd12345, 32'd12345);
        drain();

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (i == N_RANDOM / 2)
                drain();
            dividend = pick_operand();
            case ($urandom_range(0, 19))
                0:       divisor = '0;
                1, 2:    divisor = dividend + field_t'($urandom_range(0, 3));
                3, 4:    divisor = dividend - field_t'($urandom_range(0, 3));
                5, 6, 7: divisor = $urandom_range(1, 255);
                default: divisor = pick_operand();
            endcase
            send_operands(dividend, divisor);
        end

        steady = 1'b0;
        drain();
        repeat (LATENCY + 8) @(posedge clk);
        if (divisions.errors == 0 && divisions.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
